// ----- design/delimited_field_splitter_macros.svh -----
// Assertion macros for the delimited field splitter.
// Used by dfs_core, which checks its own logic; needs nothing else.
`ifndef DELIMITED_FIELD_SPLITTER_MACROS_SVH
`define DELIMITED_FIELD_SPLITTER_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define DFS_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dfs: same-cycle check failed");

// Next-cycle implication, checked out of reset.
`define DFS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dfs: next-cycle check failed");

`endif

// ----- design/dfs_pkg.sv -----
// Shared types and constants for the delimited field splitter.
// No dependencies.
`default_nettype none

package dfs_pkg;

    localparam logic [7:0] CH_NUL   = 8'd0;
    localparam logic [7:0] CH_TAB   = 8'd9;
    localparam logic [7:0] CH_LF    = 8'd10;
    localparam logic [7:0] CH_CR    = 8'd13;
    localparam logic [7:0] CH_SPACE = 8'd32;
    localparam logic [7:0] CH_HASH  = 8'd35;

    localparam logic [7:0] SEP_RESET = CH_TAB;
    localparam int unsigned ADDR_W   = 5;

    // Register index, taken from paddr[4:2]
    typedef enum logic [2:0] {
        REG_SEPARATOR  = 3'd0,
        REG_WS_MODE    = 3'd1,
        REG_SKIP_LEAD  = 3'd2,
        REG_SKIP_CMT   = 3'd3,
        REG_SKIP_EMPTY = 3'd4
    } reg_idx_t;

    typedef struct packed {
        logic [7:0] separator_byte;
        logic       whitespace_mode;
        logic       skip_leading_blanks;
        logic       skip_comments;
        logic       skip_empty_fields;
    } cfg_t;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       final_byte;
    } in_item_t;

    typedef struct packed {
        logic        char_valid;
        logic [7:0]  char_out;
        logic        field_end;
        logic        line_end;
        logic [15:0] field_index;
        logic [31:0] line_number;
    } result_t;

endpackage

`default_nettype wire

// ----- design/dfs_regs.sv -----
// Configuration registers behind the APB-style port.
// Depends on dfs_pkg.
`default_nettype none

module dfs_regs
(
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire                          psel,
    input  wire                          penable,
    input  wire                          pwrite,
    input  wire  [dfs_pkg::ADDR_W-1:0]   paddr,
    input  wire  [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready,
    output dfs_pkg::cfg_t                cfg
);

    dfs_pkg::cfg_t      cfg_reg;
    dfs_pkg::cfg_t      cfg_next;
    dfs_pkg::reg_idx_t  idx;
    logic               wr_en;

    assign idx    = dfs_pkg::reg_idx_t'(paddr[4:2]);
    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (idx)
                dfs_pkg::REG_SEPARATOR:  cfg_next.separator_byte      = pwdata[7:0];
                dfs_pkg::REG_WS_MODE:    cfg_next.whitespace_mode     = pwdata[0];
                dfs_pkg::REG_SKIP_LEAD:  cfg_next.skip_leading_blanks = pwdata[0];
                dfs_pkg::REG_SKIP_CMT:   cfg_next.skip_comments       = pwdata[0];
                dfs_pkg::REG_SKIP_EMPTY: cfg_next.skip_empty_fields   = pwdata[0];
                default:                 cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            dfs_pkg::REG_SEPARATOR:  prdata = {24'd0, cfg_reg.separator_byte};
            dfs_pkg::REG_WS_MODE:    prdata = {31'd0, cfg_reg.whitespace_mode};
            dfs_pkg::REG_SKIP_LEAD:  prdata = {31'd0, cfg_reg.skip_leading_blanks};
            dfs_pkg::REG_SKIP_CMT:   prdata = {31'd0, cfg_reg.skip_comments};
            dfs_pkg::REG_SKIP_EMPTY: prdata = {31'd0, cfg_reg.skip_empty_fields};
            default:                 prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.separator_byte      <= dfs_pkg::SEP_RESET;
            cfg_reg.whitespace_mode     <= 1'b0;
            cfg_reg.skip_leading_blanks <= 1'b0;
            cfg_reg.skip_comments       <= 1'b0;
            cfg_reg.skip_empty_fields   <= 1'b0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

`default_nettype wire

// ----- design/dfs_in_stage.sv -----
// Input register: holds one accepted item until the tokenizer takes it.
// Depends on dfs_pkg.
`default_nettype none

module dfs_in_stage
(
    input  wire                clk,
    input  wire                rst_n,
    input  wire                in_valid,
    output logic               in_ready,
    input  dfs_pkg::in_item_t  in_item,
    output logic               item_valid,
    input  wire                item_take,
    output dfs_pkg::in_item_t  item
);

    logic               valid_reg;
    logic               valid_next;
    dfs_pkg::in_item_t  item_reg;

    // a held item leaves in the same cycle a new one arrives
    assign in_ready   = !valid_reg || item_take;
    assign valid_next = (in_valid && in_ready) || (valid_reg && !item_take);
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= in_item;
        end
    end

endmodule

`default_nettype wire

// ----- design/dfs_core.sv -----
// Tokenizer: line/field state, per-byte decode and the result register.
// Depends on dfs_pkg and delimited_field_splitter_macros.svh.
`default_nettype none
`include "delimited_field_splitter_macros.svh"

module dfs_core
(
    input  wire                clk,
    input  wire                rst_n,
    input  dfs_pkg::cfg_t      cfg,
    input  wire                item_valid,
    output logic               item_take,
    input  dfs_pkg::in_item_t  item,
    output logic               out_valid,
    input  wire                out_ready,
    output dfs_pkg::result_t   result
);

    // per-line state
    logic        at_line_start_reg, at_line_start_next;
    logic        in_comment_reg, in_comment_next;
    logic        in_lead_reg, in_lead_next;
    logic        after_nul_reg, after_nul_next;
    logic        has_bytes_reg, has_bytes_next;
    logic        pending_cr_reg, pending_cr_next;
    logic [15:0] field_cnt_reg, field_cnt_next;
    logic [31:0] line_cnt_reg, line_cnt_next;

    logic              out_valid_reg, out_valid_next;
    dfs_pkg::result_t  out_reg, out_next;

    logic       fire;
    logic [7:0] b;
    logic       fin;
    logic       is_lf, is_nul, is_cr, is_ws, is_split;
    logic       comment, active, body, drop_lead;
    logic       emit_split, emit_char, body_n;
    logic       pcr_mid, close_path, emit, clear;

    assign item_take = !out_valid_reg || out_ready;
    assign fire      = item_valid && item_take;
    assign b         = item.text_byte;
    assign fin       = item.final_byte;

    always_comb
    begin
        is_lf    = (b == dfs_pkg::CH_LF);
        is_nul   = (b == dfs_pkg::CH_NUL);
        is_cr    = (b == dfs_pkg::CH_CR);
        is_ws    = (b == dfs_pkg::CH_SPACE) || (b == dfs_pkg::CH_TAB) || is_cr;
        is_split = cfg.whitespace_mode ? is_ws : (b == cfg.separator_byte);

        // first byte of a line decides whether it is a comment line
        comment   = in_comment_reg ||
                    (at_line_start_reg && cfg.skip_comments && (b == dfs_pkg::CH_HASH));
        active    = !is_lf && !comment && !after_nul_reg;
        drop_lead = cfg.skip_leading_blanks && in_lead_reg && is_ws;
        body      = active && !is_nul && !drop_lead;

        emit_split = body && is_split && (has_bytes_reg || !cfg.skip_empty_fields);
        emit_char  = body && !is_split && !is_cr;
        body_n     = emit_split || emit_char;

        pcr_mid    = active ? (emit_split && is_cr) : pending_cr_reg;
        close_path = is_lf || (fin && !body_n);
        emit       = body_n || (close_path && !comment);
        clear      = is_lf || fin;

        line_cnt_next      = at_line_start_reg ? line_cnt_reg + 32'd1 : line_cnt_reg;
        at_line_start_next = clear;
        in_comment_next    = clear ? 1'b0 : comment;
        in_lead_next       = clear ? 1'b1 : (body ? 1'b0 : in_lead_reg);
        after_nul_next     = clear ? 1'b0 : (after_nul_reg || (active && is_nul));
        pending_cr_next    = clear ? 1'b0 : pcr_mid;
        has_bytes_next     = clear ? 1'b0 :
                             (emit_split ? 1'b0 : (emit_char ? 1'b1 : has_bytes_reg));
        if (clear)
        begin
            field_cnt_next = 16'd0;
        end
        else if (emit_split && (field_cnt_reg != 16'hFFFF))
        begin
            field_cnt_next = field_cnt_reg + 16'd1;
        end
        else
        begin
            field_cnt_next = field_cnt_reg;
        end
    end

    always_comb
    begin
        out_next.char_valid  = body_n && emit_char;
        out_next.char_out    = (body_n && emit_char) ? b : 8'd0;
        out_next.field_end   = body_n ? (emit_split || fin) : !pcr_mid;
        out_next.line_end    = clear;
        out_next.field_index = field_cnt_reg;
        out_next.line_number = line_cnt_next;

        if (fire)
        begin
            out_valid_next = emit;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            at_line_start_reg <= 1'b1;
            in_comment_reg    <= 1'b0;
            in_lead_reg       <= 1'b1;
            after_nul_reg     <= 1'b0;
            has_bytes_reg     <= 1'b0;
            pending_cr_reg    <= 1'b0;
            field_cnt_reg     <= 16'd0;
            line_cnt_reg      <= 32'd0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (fire)
            begin
                at_line_start_reg <= at_line_start_next;
                in_comment_reg    <= in_comment_next;
                in_lead_reg       <= in_lead_next;
                after_nul_reg     <= after_nul_next;
                has_bytes_reg     <= has_bytes_next;
                pending_cr_reg    <= pending_cr_next;
                field_cnt_reg     <= field_cnt_next;
                line_cnt_reg      <= line_cnt_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire && emit)
        begin
            out_reg <= out_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign result    = out_reg;

    // a field byte only closes its field when it also closes the line
    `DFS_ASSERT_IMPLY(a_char_end_is_line_end, clk, rst_n,
        out_valid_reg && out_reg.char_valid && out_reg.field_end, out_reg.line_end)
    // a result with neither byte nor field end is a line-only close
    `DFS_ASSERT_IMPLY(a_bare_result_is_line_end, clk, rst_n,
        out_valid_reg && !out_reg.char_valid && !out_reg.field_end, out_reg.line_end)
    `DFS_ASSERT_IMPLY(a_no_char_zero, clk, rst_n,
        out_valid_reg && !out_reg.char_valid, out_reg.char_out == 8'd0)
    // closing a line restarts field numbering
    `DFS_ASSERT_NEXT(a_line_end_clears, clk, rst_n,
        fire && clear, (field_cnt_reg == 16'd0) && at_line_start_reg)

endmodule

`default_nettype wire

// ----- design/delimited_field_splitter.sv -----
// An accepted item passes the input register, then the result register, on its way out.
// Throughput: one text byte per cycle, set by the single-pass decode between the
// input register and the result register; a stall on the output only backs up.
// Reset (rst_n, async, low): clears line/field state, line counter and valids;
// registers return to separator tab with all options off.
// Depends on dfs_pkg, dfs_regs, dfs_in_stage, dfs_core.
`default_nettype none

module delimited_field_splitter
(
    input  wire         clk,
    input  wire         rst_n,
    // config
    input  wire         psel,
    input  wire         penable,
    input  wire         pwrite,
    input  wire  [4:0]  paddr,
    input  wire  [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // text in
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [7:0]  s_axis_tdata,   // [7:0] text_byte
    input  wire         s_axis_tlast,   // final_byte
    // fields out
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [55:0] m_axis_tdata,   // [7:0] char_out, [23:8] field_index,
                                        // [55:24] line_number
    output logic [1:0]  m_axis_tuser,   // [0] char_valid, [1] field_end
    output logic        m_axis_tlast    // line_end
);

    dfs_pkg::cfg_t      cfg;
    dfs_pkg::in_item_t  in_item;
    dfs_pkg::in_item_t  item;
    dfs_pkg::result_t   res;
    logic               item_valid;
    logic               item_take;

    assign in_item.text_byte  = s_axis_tdata;
    assign in_item.final_byte = s_axis_tlast;

    dfs_regs u_regs
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    dfs_in_stage u_in
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_item    (in_item),
        .item_valid (item_valid),
        .item_take  (item_take),
        .item       (item)
    );

    dfs_core u_core
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .item_valid (item_valid),
        .item_take  (item_take),
        .item       (item),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .result     (res)
    );

    assign m_axis_tdata = {res.line_number, res.field_index, res.char_out};
    assign m_axis_tuser = {res.field_end, res.char_valid};
    assign m_axis_tlast = res.line_end;

endmodule

`default_nettype wire

// ----- test/dfs_tb_pkg.sv -----
`timescale 1ns / 100ps
// Field-result predictor and scoreboard for the delimited field splitter bench.
// Depends on dfs_pkg for the register indexes, character codes, config and result types.

package dfs_tb_pkg;

    class field_checker;

        dfs_pkg::cfg_t    cfg;
        bit               at_line_start;
        bit               in_comment;
        bit               in_leading;
        bit               after_nul;
        bit               field_has_bytes;
        bit               pending_cr;
        logic [15:0]      field_count;
        logic [31:0]      line_count;
        dfs_pkg::result_t fields_due[$];
        int               errors;

        function new();
            cfg.separator_byte      = dfs_pkg::SEP_RESET;
            cfg.whitespace_mode     = 1'b0;
            cfg.skip_leading_blanks = 1'b0;
            cfg.skip_comments       = 1'b0;
            cfg.skip_empty_fields   = 1'b0;
            line_count = '0;
            errors     = 0;
            clear_line();
        endfunction

        function void set_reg(dfs_pkg::reg_idx_t idx, logic [31:0] val);
            case (idx)
                dfs_pkg::REG_SEPARATOR:  cfg.separator_byte      = val[7:0];
                dfs_pkg::REG_WS_MODE:    cfg.whitespace_mode     = val[0];
                dfs_pkg::REG_SKIP_LEAD:  cfg.skip_leading_blanks = val[0];
                dfs_pkg::REG_SKIP_CMT:   cfg.skip_comments       = val[0];
                dfs_pkg::REG_SKIP_EMPTY: cfg.skip_empty_fields   = val[0];
                default: ;
            endcase
        endfunction

        function void clear_line();
            at_line_start   = 1'b1;
            in_comment      = 1'b0;
            in_leading      = 1'b1;
            after_nul       = 1'b0;
            field_has_bytes = 1'b0;
            pending_cr      = 1'b0;
            field_count     = '0;
        endfunction

        function dfs_pkg::result_t make(bit cv, logic [7:0] ch, bit fe, bit le);
            dfs_pkg::result_t r;
            r.char_valid  = cv;
            r.char_out    = ch;
            r.field_end   = fe;
            r.line_end    = le;
            r.field_index = field_count;
            r.line_number = line_count;
            return r;
        endfunction

        // LF, or a final byte that made nothing: a held CR already closed the field
        function void close_line();
            if (!in_comment)
                fields_due.push_back(make(1'b0, 8'd0, !pending_cr, 1'b1));
            clear_line();
        endfunction

        function void predict_byte(logic [7:0] b, logic fin);
            dfs_pkg::result_t r;
            bit               have;
            bit               ws;
            bit               split;
            have = 1'b0;
            r    = '0;
            if (at_line_start)
            begin
                line_count++;
                at_line_start = 1'b0;
                if (cfg.skip_comments && b == dfs_pkg::CH_HASH)
                    in_comment = 1'b1;
            end
            if (b == dfs_pkg::CH_LF)
            begin
                close_line();
                return;
            end
            if (!in_comment && !after_nul)
            begin
                if (b == dfs_pkg::CH_NUL)
                begin
                    after_nul  = 1'b1;
                    pending_cr = 1'b0;
                end
                else
                begin
                    ws    = (b == dfs_pkg::CH_SPACE || b == dfs_pkg::CH_TAB ||
                             b == dfs_pkg::CH_CR);
                    split = cfg.whitespace_mode ? ws : (b == cfg.separator_byte);
                    pending_cr = 1'b0;
                    if (!(cfg.skip_leading_blanks && in_leading && ws))
                    begin
                        in_leading = 1'b0;
                        if (split)
                        begin
                            if (field_has_bytes || !cfg.skip_empty_fields)
                            begin
                                r = make(1'b0, 8'd0, 1'b1, 1'b0);
                                if (field_count != 16'hFFFF)
                                    field_count++;
                                field_has_bytes = 1'b0;
                                have = 1'b1;
                                if (b == dfs_pkg::CH_CR)
                                    pending_cr = 1'b1;
                            end
                        end
                        else if (b != dfs_pkg::CH_CR)
                        begin
                            r = make(1'b1, b, 1'b0, 1'b0);
                            field_has_bytes = 1'b1;
                            have = 1'b1;
                        end
                    end
                end
            end
            if (fin)
            begin
                if (!have)
                begin
                    close_line();
                    return;
                end
                r.field_end = 1'b1;
                r.line_end  = 1'b1;
                clear_line();
            end
            if (have)
                fields_due.push_back(r);
        endfunction

        function void check_field(dfs_pkg::result_t got);
            dfs_pkg::result_t want;
            if (fields_due.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("%0t: unexpected cv=%0b ch=%02h fe=%0b le=%0b idx=%0d line=%0d",
                             $realtime, got.char_valid, got.char_out, got.field_end,
                             got.line_end, got.field_index, got.line_number);
                return;
            end
            want = fields_due.pop_front();
            if (got.char_valid !== want.char_valid || got.char_out !== want.char_out ||
                got.field_end !== want.field_end || got.line_end !== want.line_end ||
                got.field_index !== want.field_index || got.line_number !== want.line_number)
            begin
                errors++;
                if (errors <= 10)
                begin
                    $display("%0t: expected cv=%0b ch=%02h fe=%0b le=%0b idx=%0d line=%0d",
                             $realtime, want.char_valid, want.char_out, want.field_end,
                             want.line_end, want.field_index, want.line_number);
                    $display("%0t: actual   cv=%0b ch=%02h fe=%0b le=%0b idx=%0d line=%0d",
                             $realtime, got.char_valid, got.char_out, got.field_end,
                             got.line_end, got.field_index, got.line_number);
                end
            end
        endfunction

    endclass

endpackage

// ----- test/delimited_field_splitter_tb.sv -----
`timescale 1ns / 100ps
// Bench top for delimited_field_splitter: drives text bytes and APB writes,
// checks every field result. Depends on dfs_pkg, dfs_tb_pkg and the RTL.

module delimited_field_splitter_tb;

    localparam int CYCLE_LIMIT  = 3000000;
    localparam int HOLD_CYCLES  = 400;
    localparam int PHASE_ITEMS  = 150;

    logic        clk;
    logic        rst_n          = 1'b0;
    logic        psel           = 1'b0;
    logic        penable        = 1'b0;
    logic        pwrite         = 1'b0;
    logic [4:0]  paddr          = '0;
    logic [31:0] pwdata         = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        s_axis_tvalid  = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata   = '0;
    logic        s_axis_tlast   = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready  = 1'b0;
    logic [55:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;
    logic        m_axis_tlast;

    dfs_tb_pkg::field_checker sb;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    bit pressure_on    = 1'b0;
    bit hold_on        = 1'b0;
    int cycles         = 0;
    int bytes_sent     = 0;

    delimited_field_splitter DUT
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // long receiver hold-off, counted here while the sender keeps offering items
    initial
    begin
        wait (pressure_on);
        @(posedge clk);
        hold_on <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_on <= 1'b0;
    end

    // Result side: check, then choose tready for the next cycle
    always @(posedge clk)
    begin
        dfs_pkg::result_t got;
        if (m_axis_tvalid && m_axis_tready)
        begin
            got.char_valid  = m_axis_tuser[0];
            got.field_end   = m_axis_tuser[1];
            got.line_end    = m_axis_tlast;
            got.char_out    = m_axis_tdata[7:0];
            got.field_index = m_axis_tdata[23:8];
            got.line_number = m_axis_tdata[55:24];
            sb.check_field(got);
        end
        if (hold_on)
            m_axis_tready <= 1'b0;
        else
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    task automatic send_item(logic [7:0] b, logic fin);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= fin;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        sb.predict_byte(b, fin);
        bytes_sent++;
    endtask

    task automatic send_text(string s, bit fin);
        for (int i = 0; i < s.len(); i++)
            send_item(s[i], fin && (i == s.len() - 1));
    endtask

    task automatic write_reg(dfs_pkg::reg_idx_t idx, logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.set_reg(idx, val);
        @(posedge clk);
    endtask

    task automatic set_config(logic [7:0] sep, bit ws, bit lead, bit cmt, bit empty);
        write_reg(dfs_pkg::REG_SEPARATOR, {24'd0, sep});
        write_reg(dfs_pkg::REG_WS_MODE, {31'd0, ws});
        write_reg(dfs_pkg::REG_SKIP_LEAD, {31'd0, lead});
        write_reg(dfs_pkg::REG_SKIP_CMT, {31'd0, cmt});
        write_reg(dfs_pkg::REG_SKIP_EMPTY, {31'd0, empty});
    endtask

    // Drop valid, let every expected field arrive, then cover items that made none
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (sb.fields_due.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    function automatic logic [7:0] pick_byte();
        int r;
        r = $urandom_range(99);
        if (r < 55)
            return 8'($urandom_range(33, 126));
        else if (r < 70)
            return sb.cfg.separator_byte;
        else if (r < 76)
            return dfs_pkg::CH_SPACE;
        else if (r < 81)
            return dfs_pkg::CH_TAB;
        else if (r < 85)
            return dfs_pkg::CH_CR;
        else if (r < 87)
            return dfs_pkg::CH_NUL;
        return 8'($urandom_range(255));
    endfunction

    // Mostly well-formed lines with random content; a tenth is raw noise
    task automatic send_line();
        int len;
        len = $urandom_range(12);
        if ($urandom_range(99) < 10)
        begin
            repeat (len + 1)
                send_item(8'($urandom_range(255)), $urandom_range(49) == 0);
            return;
        end
        if ($urandom_range(99) < 15)
            send_item(dfs_pkg::CH_HASH, 1'b0);
        if ($urandom_range(99) < 30)
            repeat ($urandom_range(1, 3))
                send_item($urandom_range(1) ? dfs_pkg::CH_SPACE : dfs_pkg::CH_TAB, 1'b0);
        for (int i = 0; i < len; i++)
            send_item(pick_byte(), 1'b0);
        if ($urandom_range(99) < 20)
            send_item(dfs_pkg::CH_CR, 1'b0);
        if ($urandom_range(99) < 5)
            send_item(pick_byte(), 1'b1);
        else
            send_item(dfs_pkg::CH_LF, 1'b0);
    endtask

    initial
    begin
        int stop_at;
        sb = new();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: tab separator, all options off
        send_text("a\t\t", 1'b0);
        send_item(8'hFF, 1'b0);
        send_item(dfs_pkg::CH_LF, 1'b0);
        send_item(dfs_pkg::CH_LF, 1'b0);
        send_text("x", 1'b0);
        send_item(dfs_pkg::CH_NUL, 1'b0);
        send_text("q\n", 1'b0);
        send_text("#\r\n", 1'b0);
        settle();

        // whitespace splitting with every skip option on
        set_config(8'hFF, 1'b1, 1'b1, 1'b1, 1'b1);
        send_text(" #z\n", 1'b0);
        send_text("#c\n", 1'b0);
        send_text("a\r\n", 1'b0);
        send_text("b c", 1'b1);
        send_text("d ", 1'b1);
        settle();

        for (int p = 0; p < 6; p++)
        begin
            case (p)
                0: set_config(8'h2C, 1'b0, 1'b0, 1'b1, 1'b0);
                1: set_config(8'h00, 1'b0, 1'b1, 1'b0, 1'b1);
                2: set_config(8'hFF, 1'b0, 1'b1, 1'b1, 1'b1);
                3: set_config(8'($urandom_range(255)), 1'b1, 1'b1, 1'b1, 1'b1);
                default: set_config($urandom_range(3) == 0 ? dfs_pkg::CH_SPACE :
                                                             8'($urandom_range(255)),
                                    1'($urandom_range(1)), 1'($urandom_range(1)),
                                    1'($urandom_range(1)), 1'($urandom_range(1)));
            endcase
            case (p % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 71; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 71; end
                default: begin send_idle_pct = 10; recv_stall_pct = 10; end
            endcase
            // long receiver hold-off while bytes keep coming
            if (p == 4)
                pressure_on = 1'b1;
            stop_at = bytes_sent + PHASE_ITEMS;
            while (bytes_sent < stop_at)
                send_line();
            settle();
        end

        if (sb.errors == 0 && sb.fields_due.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
